FILE: sv/source_token_scanner_defines.svh
// Assertion macros for the token scanner checker.
`ifndef SOURCE_TOKEN_SCANNER_DEFINES_SVH
`define SOURCE_TOKEN_SCANNER_DEFINES_SVH
// Implication checked every clock, muted during reset.
`define STS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%s failed", "label");
// Next-cycle implication checked every clock, muted during reset.
`define STS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%s failed", "label");
`endif

FILE: sv/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Token kinds, scan modes and the front-to-back record of the token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int KIND_W = 6;
  localparam int KW_COUNT = 20;
  localparam int KW_SLOT = 16;

  localparam logic [KIND_W-1:0] K_IDENT    = 6'd0;
  localparam logic [KIND_W-1:0] K_NUMLIT   = 6'd21;
  localparam logic [KIND_W-1:0] K_STRLIT   = 6'd22;
  localparam logic [KIND_W-1:0] K_PLUS     = 6'd23;
  localparam logic [KIND_W-1:0] K_MINUS    = 6'd24;
  localparam logic [KIND_W-1:0] K_STAR     = 6'd25;
  localparam logic [KIND_W-1:0] K_SLASH    = 6'd26;
  localparam logic [KIND_W-1:0] K_PERCENT  = 6'd27;
  localparam logic [KIND_W-1:0] K_LPAREN   = 6'd28;
  localparam logic [KIND_W-1:0] K_RPAREN   = 6'd29;
  localparam logic [KIND_W-1:0] K_LBRACE   = 6'd30;
  localparam logic [KIND_W-1:0] K_RBRACE   = 6'd31;
  localparam logic [KIND_W-1:0] K_LBRACKET = 6'd32;
  localparam logic [KIND_W-1:0] K_RBRACKET = 6'd33;
  localparam logic [KIND_W-1:0] K_COLON    = 6'd34;
  localparam logic [KIND_W-1:0] K_SEMI     = 6'd35;
  localparam logic [KIND_W-1:0] K_ASSIGN   = 6'd36;
  localparam logic [KIND_W-1:0] K_EQEQ     = 6'd37;
  localparam logic [KIND_W-1:0] K_NOTEQ    = 6'd38;
  localparam logic [KIND_W-1:0] K_LT       = 6'd39;
  localparam logic [KIND_W-1:0] K_LE       = 6'd40;
  localparam logic [KIND_W-1:0] K_GT       = 6'd41;
  localparam logic [KIND_W-1:0] K_GE       = 6'd42;
  localparam logic [KIND_W-1:0] K_UNKNOWN  = 6'd43;
  localparam logic [KIND_W-1:0] K_UNTERM   = 6'd44;
  localparam logic [KIND_W-1:0] K_END      = 6'd45;

  // One-hot scan modes
  typedef enum logic [10:0] {
    M_IDLE   = 11'b00000000001,
    M_WORD   = 11'b00000000010,
    M_DIGITS = 11'b00000000100,
    M_STR    = 11'b00000001000,
    M_ESC    = 11'b00000010000,
    M_REMARK = 11'b00000100000,
    M_MINUS  = 11'b00001000000,
    M_EQ     = 11'b00010000000,
    M_BANG   = 11'b00100000000,
    M_LT     = 11'b01000000000,
    M_GT     = 11'b10000000000
  } mode_t;

  // Keyword spellings, first character in the low byte
  function automatic logic [KW_SLOT*8-1:0] kw_text(input int k);
    logic [KW_SLOT*8-1:0] t;
    string s;
    t = '0;
    case (k)
      0: s = "let";          1: s = "number";      2: s = "array";
      3: s = "text";         4: s = "of";          5: s = "if";
      6: s = "then";         7: s = "else";        8: s = "end_if";
      9: s = "loop";         10: s = "while";      11: s = "do";
      12: s = {"end_", "loop"};
      13: s = "define";      14: s = "returns";    15: s = "return";
      16: s = {"read_", "number"};
      17: s = {"print_", "number"};
      18: s = {"print_", "text"};
      default: s = "size_of";
    endcase
    for (int i = 0; i < KW_SLOT; i++) begin
      if (i < s.len()) t[i*8 +: 8] = s[i];
    end
    return t;
  endfunction

  function automatic int kw_len(input int k);
    case (k)
      0: return 3;   1: return 6;   2: return 5;   3: return 4;   4: return 2;
      5: return 2;   6: return 4;   7: return 4;   8: return 6;   9: return 4;
      10: return 5;  11: return 2;  12: return 8;  13: return 6;  14: return 7;
      15: return 6;  16: return 11; 17: return 12; 18: return 10; default: return 7;
    endcase
  endfunction

  // Fields of one token: 6-bit kind, 16-bit line, column and length, last flag
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [15:0]       line;
    logic [15:0]       column;
    logic [15:0]       length;
    logic              last;
  } token_t;

endpackage

FILE: sv/sts_front.sv
// ----------------------------------------------------------------------------
// sts_front
// Classifies each byte, tracks position and scan mode, and writes up to two
// finished token records per item into the queue.
// ----------------------------------------------------------------------------
module sts_front #(
  parameter int MAX_KEYWORD_LEN = 12,
  parameter int POSITION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [7:0]        byte_value,
  input  logic              end_of_input,
  output logic [1:0]        push_count,
  output sts_pkg::token_t   tok0,
  output sts_pkg::token_t   tok1
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam int LEN_W = $clog2(MAX_KEYWORD_LEN);

  sts_pkg::mode_t mode, mode_next;
  logic [POSITION_BITS-1:0] line_count, line_next;
  logic [POSITION_BITS-1:0] column_count, column_next;
  logic [POSITION_BITS-1:0] start_line, start_line_next;
  logic [POSITION_BITS-1:0] start_column, start_column_next;
  logic [POSITION_BITS-1:0] char_count, char_count_next;
  logic word_too_long, word_too_long_next;
  logic [7:0] word_buffer [MAX_KEYWORD_LEN];
  logic wb_we;
  logic [LEN_W-1:0] wb_addr;

  logic [7:0] c;
  logic is_digit, is_alpha, is_word, is_space;
  logic [sts_pkg::KIND_W-1:0] word_kind, single_kind;

  assign c = byte_value;
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  assign is_word = is_alpha || is_digit || (c == 8'h5f);
  assign is_space = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));

  function automatic logic [15:0] clip(input logic [POSITION_BITS-1:0] v);
    logic [POSITION_BITS+15:0] w;
    w = {16'd0, v};
    return (w > (POSITION_BITS+16)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  // Keyword match over the stored word, all twenty in parallel
  always_comb begin
    logic [sts_pkg::KW_SLOT*8-1:0] t;
    logic hit;
    word_kind = sts_pkg::K_IDENT;
    for (int k = sts_pkg::KW_COUNT - 1; k >= 0; k--) begin
      t = sts_pkg::kw_text(k);
      hit = !word_too_long && (sts_pkg::kw_len(k) <= MAX_KEYWORD_LEN)
            && (char_count == POSITION_BITS'(sts_pkg::kw_len(k)));
      for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
        if (i < sts_pkg::kw_len(k) && word_buffer[i] != t[i*8 +: 8]) hit = 1'b0;
      end
      if (hit) word_kind = sts_pkg::KIND_W'(k + 1);
    end
  end

  // Single-character operators
  always_comb begin
    case (c)
      8'h2b: single_kind = sts_pkg::K_PLUS;
      8'h2a: single_kind = sts_pkg::K_STAR;
      8'h2f: single_kind = sts_pkg::K_SLASH;
      8'h25: single_kind = sts_pkg::K_PERCENT;
      8'h28: single_kind = sts_pkg::K_LPAREN;
      8'h29: single_kind = sts_pkg::K_RPAREN;
      8'h7b: single_kind = sts_pkg::K_LBRACE;
      8'h7d: single_kind = sts_pkg::K_RBRACE;
      8'h5b: single_kind = sts_pkg::K_LBRACKET;
      8'h5d: single_kind = sts_pkg::K_RBRACKET;
      8'h3a: single_kind = sts_pkg::K_COLON;
      8'h3b: single_kind = sts_pkg::K_SEMI;
      default: single_kind = sts_pkg::K_UNKNOWN;
    endcase
  end

  // Next state and emitted tokens
  always_comb begin
    logic restart, pend;
    logic [sts_pkg::KIND_W-1:0] pk;
    sts_pkg::token_t e [2];
    int n;
    logic [15:0] pl, pc, pn;
    mode_next = mode;
    line_next = line_count;
    column_next = column_count;
    start_line_next = start_line;
    start_column_next = start_column;
    char_count_next = char_count;
    word_too_long_next = word_too_long;
    wb_we = 1'b0;
    wb_addr = '0;
    restart = 1'b0;
    pend = 1'b0;
    pk = sts_pkg::K_IDENT;
    e[0] = '0;
    e[1] = '0;
    n = 0;
    pl = clip(start_line);
    pc = clip(start_column);
    pn = clip(char_count);
    if (end_of_input) begin
      pend = 1'b1;
      unique case (mode)
        sts_pkg::M_WORD:   pk = word_kind;
        sts_pkg::M_DIGITS: pk = sts_pkg::K_NUMLIT;
        sts_pkg::M_STR, sts_pkg::M_ESC: pk = sts_pkg::K_UNTERM;
        sts_pkg::M_MINUS:  pk = sts_pkg::K_MINUS;
        sts_pkg::M_EQ:     pk = sts_pkg::K_ASSIGN;
        sts_pkg::M_BANG:   pk = sts_pkg::K_UNKNOWN;
        sts_pkg::M_LT:     pk = sts_pkg::K_LT;
        sts_pkg::M_GT:     pk = sts_pkg::K_GT;
        default:           pend = 1'b0;
      endcase
      if (pend) begin
        e[0] = '{kind: pk, line: pl, column: pc, length: pn, last: 1'b0};
        n = 1;
      end
      e[n] = '{kind: sts_pkg::K_END, line: clip(line_count),
               column: clip(column_count), length: 16'd0, last: 1'b1};
      n = n + 1;
      mode_next = sts_pkg::M_IDLE;
      line_next = POSITION_BITS'(1);
      column_next = '0;
    end else begin
      if (c == 8'h0a) begin
        line_next = sat_inc(line_count);
        column_next = '0;
      end else begin
        column_next = sat_inc(column_count);
      end
      // continue the pending token
      unique case (mode)
        sts_pkg::M_WORD: begin
          if (is_word) begin
            if (char_count < POSITION_BITS'(MAX_KEYWORD_LEN)) begin
              wb_we = 1'b1;
              wb_addr = char_count[LEN_W-1:0];
            end else begin
              word_too_long_next = 1'b1;
            end
            char_count_next = sat_inc(char_count);
          end else begin
            pend = 1'b1; pk = word_kind; restart = 1'b1;
          end
        end
        sts_pkg::M_DIGITS: begin
          if (is_digit) char_count_next = sat_inc(char_count);
          else begin pend = 1'b1; pk = sts_pkg::K_NUMLIT; restart = 1'b1; end
        end
        sts_pkg::M_STR: begin
          if (c == 8'h0a) begin
            pend = 1'b1; pk = sts_pkg::K_UNTERM; restart = 1'b1;
          end else begin
            char_count_next = sat_inc(char_count);
            if (c == 8'h22) begin
              pend = 1'b1; pk = sts_pkg::K_STRLIT; pn = clip(sat_inc(char_count));
              mode_next = sts_pkg::M_IDLE;
            end else if (c == 8'h5c) begin
              mode_next = sts_pkg::M_ESC;
            end
          end
        end
        sts_pkg::M_ESC: begin
          char_count_next = sat_inc(char_count);
          mode_next = sts_pkg::M_STR;
        end
        sts_pkg::M_REMARK: restart = (c == 8'h0a);
        sts_pkg::M_MINUS: begin
          if (is_digit) begin
            char_count_next = POSITION_BITS'(2);
            mode_next = sts_pkg::M_DIGITS;
          end else begin
            pend = 1'b1; pk = sts_pkg::K_MINUS; restart = 1'b1;
          end
        end
        sts_pkg::M_EQ, sts_pkg::M_BANG, sts_pkg::M_LT, sts_pkg::M_GT: begin
          pend = 1'b1;
          if (c == 8'h3d) begin
            pn = 16'd2;
            char_count_next = POSITION_BITS'(2);
            mode_next = sts_pkg::M_IDLE;
            unique case (mode)
              sts_pkg::M_EQ:   pk = sts_pkg::K_EQEQ;
              sts_pkg::M_BANG: pk = sts_pkg::K_NOTEQ;
              sts_pkg::M_LT:   pk = sts_pkg::K_LE;
              default:         pk = sts_pkg::K_GE;
            endcase
          end else begin
            restart = 1'b1;
            unique case (mode)
              sts_pkg::M_EQ:   pk = sts_pkg::K_ASSIGN;
              sts_pkg::M_BANG: pk = sts_pkg::K_UNKNOWN;
              sts_pkg::M_LT:   pk = sts_pkg::K_LT;
              default:         pk = sts_pkg::K_GT;
            endcase
          end
        end
        default: restart = 1'b1;
      endcase
      if (pend) begin
        e[0] = '{kind: pk, line: pl, column: pc, length: pn, last: 1'b0};
        n = 1;
      end
      // start a new token from idle
      if (restart) begin
        mode_next = sts_pkg::M_IDLE;
        if (!is_space) begin
          if (c == 8'h7e) begin
            mode_next = sts_pkg::M_REMARK;
          end else begin
            start_line_next = line_next;
            start_column_next = column_next;
            char_count_next = POSITION_BITS'(1);
            if (is_alpha || c == 8'h5f) begin
              mode_next = sts_pkg::M_WORD;
              wb_we = 1'b1;
              wb_addr = '0;
              word_too_long_next = 1'b0;
            end else if (is_digit) mode_next = sts_pkg::M_DIGITS;
            else if (c == 8'h22) mode_next = sts_pkg::M_STR;
            else if (c == 8'h2d) mode_next = sts_pkg::M_MINUS;
            else if (c == 8'h3d) mode_next = sts_pkg::M_EQ;
            else if (c == 8'h21) mode_next = sts_pkg::M_BANG;
            else if (c == 8'h3c) mode_next = sts_pkg::M_LT;
            else if (c == 8'h3e) mode_next = sts_pkg::M_GT;
            else begin
              e[n] = '{kind: single_kind, line: clip(line_next),
                       column: clip(column_next), length: 16'd1, last: 1'b0};
              n = n + 1;
            end
          end
        end
      end
      if (n == 2) e[1].last = 1'b1;
      else if (n == 1) e[0].last = 1'b1;
    end
    tok0 = e[0];
    tok1 = e[1];
    push_count = in_fire ? 2'(n) : 2'd0;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sts_pkg::M_IDLE;
      line_count <= POSITION_BITS'(1);
      column_count <= '0;
      start_line <= '0;
      start_column <= '0;
      char_count <= '0;
      word_too_long <= 1'b0;
    end else if (in_fire) begin
      mode <= mode_next;
      line_count <= line_next;
      column_count <= column_next;
      start_line <= start_line_next;
      start_column <= start_column_next;
      char_count <= char_count_next;
      word_too_long <= word_too_long_next;
    end
  end

  // Word buffer
  always_ff @(posedge clk) begin
    if (in_fire && wb_we) word_buffer[wb_addr] <= c;
  end

endmodule

FILE: sv/sts_queue.sv
// ----------------------------------------------------------------------------
// sts_queue
// Token queue between classifier and output; takes up to two items per
// cycle, gives one while the output is ready.
// ----------------------------------------------------------------------------
module sts_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_count,
  input  sts_pkg::token_t tok0,
  input  sts_pkg::token_t tok1,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output sts_pkg::token_t out_tok
);

  localparam int DEPTH = 4;

  sts_pkg::token_t store [DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill;
  logic pop;

  assign out_valid = (fill != 3'd0);
  assign pop = out_valid && out_ready;
  assign out_tok = store[rd_ptr];
  // room for two more, not counting this cycle's pop
  assign room = (fill <= 3'd2);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + 2'(pop);
      fill <= fill + 3'(push_count) - 3'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) store[wr_ptr] <= tok0;
    if (push_count == 2'd2) store[wr_ptr + 2'd1] <= tok1;
  end

endmodule

FILE: sv/source_token_scanner.sv
// ----------------------------------------------------------------------------
// source_token_scanner
// Byte-stream lexer giving kind, line, column and length of each token.
// ----------------------------------------------------------------------------
// One source byte (or end marker) is taken per cycle while the four-entry
// token queue has room for two tokens; each item yields zero to two tokens,
// which leave one per cycle unless stalled. The classifier is combinational,
// so the sustained rate is one item a cycle unless tokens outnumber items.
module source_token_scanner #(
  parameter int MAX_KEYWORD_LEN = 12,
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // byte_value
  input  logic        s_tuser,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // token_kind[5:0], token_line, token_column, token_length
  output logic        m_tlast    // last_of_run
);

  logic [1:0] push_count;
  sts_pkg::token_t tok0, tok1, out_tok;
  logic room;

  assign s_tready = room;

  sts_front #(.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN), .POSITION_BITS(POSITION_BITS)) u_front (
    .clk, .rst, .in_fire(s_tvalid && s_tready), .byte_value(s_tdata),
    .end_of_input(s_tuser), .push_count, .tok0, .tok1
  );

  sts_queue u_queue (
    .clk, .rst, .push_count, .tok0, .tok1, .room,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_tok
  );

  assign m_tdata = {2'b00, out_tok.length, out_tok.column, out_tok.line, out_tok.kind};
  assign m_tlast = out_tok.last;

endmodule

FILE: sv/sts_checker.sv
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks for the token scanner.
// ----------------------------------------------------------------------------
`include "source_token_scanner_defines.svh"
module sts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast
);
  // stalled output item holds
  `STS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // end token always closes a run
  `STS_ASSERT_IMP(a_end_last, m_tvalid && m_tdata[5:0] == sts_pkg::K_END, m_tlast)
  // an end marker always produces output next cycle
  `STS_ASSERT_NEXT(a_end_out, s_tvalid && s_tready && s_tuser, m_tvalid)
  // end token has zero length
  `STS_ASSERT_IMP(a_end_len, m_tvalid && m_tdata[5:0] == sts_pkg::K_END, m_tdata[53:38] == 16'd0)
endmodule

bind source_token_scanner sts_checker u_sts_checker (.*);
